### rtl/anbs_pkg.sv
package anbs_pkg;

  localparam int unsigned SIZE_CAP    = 65535;
  localparam int unsigned COUNT_CAP   = 16383;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [7:0]  START_LAST  = 8'h01;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  unit_type;
    logic [1:0]  ref_priority;
    logic        forbidden_flag;
    logic [15:0] unit_size;
    logic [13:0] unit_index;
    logic        packet_done;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  header;
    logic [13:0] index;
    logic        done;
  } nal_desc_t;

endpackage

### rtl/anbs_queue.sv
module anbs_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             wr_ready,
  output logic             rd_valid,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data
);
  import anbs_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign do_wr    = wr_en && wr_ready;
  assign do_rd    = rd_en && rd_valid;
  assign rd_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/anbs_front.sv
module anbs_front #(
  parameter int unsigned MAX_PACKET_BYTES = 65535,
  parameter int unsigned POS_W = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  anbs_pkg::in_item_t  item,
  output logic                emit,
  output anbs_pkg::nal_desc_t desc,
  output logic [POS_W-1:0]    end_pos,
  output logic [POS_W-1:0]    start_pos
);
  import anbs_pkg::*;

  logic [23:0]      window;
  logic [POS_W-1:0] pos;
  logic             pending;
  logic [7:0]       pending_header;
  logic [POS_W-1:0] pending_start;
  logic             header_due;
  logic [13:0]      unit_count;

  logic [23:0]      window_next;
  logic [POS_W-1:0] pos_next;
  logic             pending_next;
  logic [7:0]       pending_header_next;
  logic [POS_W-1:0] pending_start_next;
  logic             header_due_next;
  logic [13:0]      unit_count_next;
  logic             start_code;

  assign start_code = !item.final_byte && (pos >= POS_W'(3)) && (window == '0) &&
                      (item.data_byte == START_LAST) &&
                      !(pending && (pending_start == pos - POS_W'(3)));

  always_comb begin
    window_next         = window;
    pos_next            = pos;
    pending_next        = pending;
    pending_header_next = pending_header;
    pending_start_next  = pending_start;
    header_due_next     = header_due;
    unit_count_next     = unit_count;
    emit                = 1'b0;
    desc.header         = pending_header;
    desc.index          = unit_count;
    desc.done           = 1'b0;
    end_pos             = pos;
    start_pos           = pending_start;
    if (accept) begin
      if (header_due) begin
        header_due_next     = 1'b0;
        pending_header_next = item.data_byte;
        pending_start_next  = pos;
        pending_next        = 1'b1;
        if (unit_count < 14'(COUNT_CAP)) begin
          unit_count_next = unit_count + 1'b1;
        end
      end else if (start_code) begin
        if (pending) begin
          emit         = 1'b1;
          pending_next = 1'b0;
        end
        header_due_next = 1'b1;
      end
      if (item.final_byte) begin
        if (pending_next && !emit) begin
          emit        = 1'b1;
          desc.header = pending_header_next;
          desc.index  = unit_count_next;
          desc.done   = 1'b1;
          start_pos   = pending_start_next;
        end
        window_next         = '0;
        pos_next            = '0;
        pending_next        = 1'b0;
        pending_header_next = '0;
        pending_start_next  = '0;
        header_due_next     = 1'b0;
        unit_count_next     = '0;
      end else begin
        window_next = {window[15:0], item.data_byte};
        if (pos < POS_W'(MAX_PACKET_BYTES)) begin
          pos_next = pos + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window         <= '0;
      pos            <= '0;
      pending        <= 1'b0;
      pending_header <= '0;
      pending_start  <= '0;
      header_due     <= 1'b0;
      unit_count     <= '0;
    end else begin
      window         <= window_next;
      pos            <= pos_next;
      pending        <= pending_next;
      pending_header <= pending_header_next;
      pending_start  <= pending_start_next;
      header_due     <= header_due_next;
      unit_count     <= unit_count_next;
    end
  end

endmodule

### rtl/anbs_back.sv
module anbs_back #(
  parameter int unsigned POS_W = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_pop,
  input  anbs_pkg::nal_desc_t desc,
  input  logic [POS_W-1:0]    end_pos,
  input  logic [POS_W-1:0]    start_pos,
  output logic                empty,
  input  logic                pop,
  output anbs_pkg::out_item_t result
);
  import anbs_pkg::*;

  localparam int unsigned CW = (POS_W > 16) ? POS_W : 16;

  logic             valid;
  logic [POS_W-1:0] diff;
  logic [CW-1:0]    trimmed;
  logic [15:0]      size;

  assign diff    = end_pos - start_pos;
  assign trimmed = CW'(diff - POS_W'(3));
  assign q_pop   = q_valid && (!valid || pop);
  assign empty   = !valid;

  always_comb begin
    if (diff <= POS_W'(3)) begin
      size = 16'd1;
    end else if (trimmed > CW'(SIZE_CAP)) begin
      size = 16'(SIZE_CAP);
    end else begin
      size = trimmed[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      result.unit_type      <= desc.header[4:0];
      result.ref_priority   <= desc.header[6:5];
      result.forbidden_flag <= desc.header[7];
      result.unit_size      <= size;
      result.unit_index     <= desc.index;
      result.packet_done    <= desc.done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (q_pop) begin
      valid <= 1'b1;
    end else if (pop) begin
      valid <= 1'b0;
    end
  end

endmodule

### rtl/annexb_nal_unit_scanner.sv
// Channel   Direction  Handshake            Payload
// item      in         push / full          anbs_pkg::in_item_t (data_byte, final_byte)
// result    out        empty / pop          anbs_pkg::out_item_t (one NAL per item)
//
// One byte is taken every cycle while the two-entry queue between the scanner and
// the size stage has room; once the byte that ends a NAL is accepted, its result
// passes through that queue and then the output register to the result ports.
// Reset is synchronous and empties the scanner, the queue and the output register.
// When the result side stalls, the output register and then the queue fill, and full
// rises once three NALs are waiting.
module annexb_nal_unit_scanner #(
  parameter int unsigned MAX_PACKET_BYTES = 65535
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  anbs_pkg::in_item_t  item,
  output logic                empty,
  input  logic                pop,
  output anbs_pkg::out_item_t result
);
  import anbs_pkg::*;

  localparam int unsigned POS_W  = $clog2(MAX_PACKET_BYTES + 1);
  localparam int unsigned DESC_W = $bits(nal_desc_t);
  localparam int unsigned REC_W  = DESC_W + 2 * POS_W;

  logic             accept;
  logic             emit;
  nal_desc_t        f_desc;
  logic [POS_W-1:0] f_end;
  logic [POS_W-1:0] f_start;
  logic             q_ready;
  logic             q_valid;
  logic             q_pop;
  logic [REC_W-1:0] q_rec;
  nal_desc_t        b_desc;
  logic [POS_W-1:0] b_end;
  logic [POS_W-1:0] b_start;

  assign full   = !q_ready;
  assign accept = push && q_ready;
  assign b_desc  = q_rec[REC_W-1 -: DESC_W];
  assign b_end   = q_rec[2*POS_W-1 -: POS_W];
  assign b_start = q_rec[POS_W-1:0];

  anbs_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES),
    .POS_W(POS_W)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .item(item),
    .emit(emit),
    .desc(f_desc),
    .end_pos(f_end),
    .start_pos(f_start)
  );

  anbs_queue #(
    .WIDTH(REC_W)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .wr_en(accept && emit),
    .wr_data({f_desc, f_end, f_start}),
    .wr_ready(q_ready),
    .rd_valid(q_valid),
    .rd_en(q_pop),
    .rd_data(q_rec)
  );

  anbs_back #(
    .POS_W(POS_W)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_pop(q_pop),
    .desc(b_desc),
    .end_pos(b_end),
    .start_pos(b_start),
    .empty(empty),
    .pop(pop),
    .result(result)
  );

endmodule
